// ===== hw/rtl/lpd_pkg.sv =====
// Shared types and constants for the length-prefix deframer.
package lpd_pkg;

	localparam int unsigned HdrBytes     = 4;
	localparam int unsigned LenW         = 32;
	localparam int unsigned ByteW        = 8;
	localparam int unsigned PaddrW       = 3;
	localparam int unsigned DataW        = 32;
	localparam logic [LenW-1:0] MaxFrameReset = 32'd4096;

	// register index, taken from paddr[2]
	localparam logic RegMaxFrame = 1'b0;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_ERROR   = 2'd2
	} phase_t;

	typedef struct packed {
		logic             vld;
		logic [ByteW-1:0] data;
		logic             last;
		logic             err;
	} result_t;

endpackage

// ===== hw/rtl/lpd_apb_regs.sv =====
// APB register block holding the maximum frame length.
module lpd_apb_regs import lpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [PaddrW-1:0] paddr,
	input  logic [DataW-1:0]  pwdata,
	output logic [DataW-1:0]  prdata,
	output logic              pready,
	output logic [LenW-1:0]   max_frame_bytes
);

	logic [LenW-1:0] max_frame_q;
	logic            wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == RegMaxFrame);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= MaxFrameReset;
		end else if (wr_en) begin
			max_frame_q <= pwdata;
		end
	end

	assign prdata          = (paddr[2] == RegMaxFrame) ? max_frame_q : '0;
	assign max_frame_bytes = max_frame_q;

endmodule

// ===== hw/rtl/length_prefix_deframer.sv =====
// Top level of the length-prefix deframer: header parse, payload pass-through, error lock.
//
// Channel | Direction | Handshake           | Beat payload
// in      | sink      | in_valid/in_stall   | rx_byte
// out     | source    | out_valid/out_stall | payload_byte, frame_end, framing_error
// cfg     | APB slave | psel/penable/pready | max_frame_bytes at byte address 0
//
// One beat per cycle unless stalled; a result appears on the output register the cycle
// after its input beat. Header beats give no result but an error on a bad length; beats
// after an error give none. in_stall is asserted only while the output register is full
// and stalled. Reset clears the phase, header count, length and payload count; a framing
// error holds until reset.
module length_prefix_deframer import lpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ByteW-1:0]  rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ByteW-1:0]  payload_byte,
	output logic              frame_end,
	output logic              framing_error,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [PaddrW-1:0] paddr,
	input  logic [DataW-1:0]  pwdata,
	output logic [DataW-1:0]  prdata,
	output logic              pready
);

	logic [LenW-1:0] max_frame;

	phase_t          phase_q, phase_nxt;
	logic [1:0]      hdr_cnt_q, hdr_cnt_nxt;
	logic [LenW-1:0] frame_len_q, frame_len_nxt;
	logic [LenW-1:0] pay_cnt_q, pay_cnt_nxt;
	logic [LenW-1:0] len_asm;
	logic [LenW-1:0] cnt_inc;
	result_t         res;

	logic             out_valid_q;
	logic [ByteW-1:0] payload_byte_q;
	logic             frame_end_q;
	logic             framing_error_q;
	logic             accept;

	lpd_apb_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.max_frame_bytes (max_frame)
	);

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		len_asm = frame_len_q;
		len_asm[hdr_cnt_q*ByteW +: ByteW] = rx_byte;
		cnt_inc = pay_cnt_q + 1'b1;
	end

	// next state
	always_comb begin
		phase_nxt     = phase_q;
		hdr_cnt_nxt   = hdr_cnt_q;
		frame_len_nxt = frame_len_q;
		pay_cnt_nxt   = pay_cnt_q;
		case (phase_q)
			PH_HEADER: begin
				hdr_cnt_nxt   = hdr_cnt_q + 2'd1;
				frame_len_nxt = len_asm;
				if (hdr_cnt_q == 2'(HdrBytes - 1)) begin
					if (len_asm == '0 || len_asm > max_frame) begin
						phase_nxt = PH_ERROR;
					end else begin
						phase_nxt   = PH_PAYLOAD;
						pay_cnt_nxt = '0;
					end
				end
			end
			PH_PAYLOAD: begin
				pay_cnt_nxt = cnt_inc;
				if (cnt_inc == frame_len_q) begin
					phase_nxt     = PH_HEADER;
					hdr_cnt_nxt   = '0;
					frame_len_nxt = '0;
					pay_cnt_nxt   = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// result for this beat
	always_comb begin
		res = '0;
		case (phase_q)
			PH_HEADER: begin
				if (hdr_cnt_q == 2'(HdrBytes - 1) &&
				    (len_asm == '0 || len_asm > max_frame)) begin
					res.vld = 1'b1;
					res.err = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				res.vld  = 1'b1;
				res.data = rx_byte;
				res.last = (cnt_inc == frame_len_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hdr_cnt_q   <= '0;
			frame_len_q <= '0;
			pay_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_nxt;
				hdr_cnt_q   <= hdr_cnt_nxt;
				frame_len_q <= frame_len_nxt;
				pay_cnt_q   <= pay_cnt_nxt;
			end
			if (accept && res.vld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res.vld) begin
			payload_byte_q  <= res.data;
			frame_end_q     <= res.last;
			framing_error_q <= res.err;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = payload_byte_q;
	assign frame_end     = frame_end_q;
	assign framing_error = framing_error_q;

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |=> phase_q == PH_ERROR)
		else $error("error phase left without reset");

	a_err_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && framing_error |-> payload_byte == '0 && !frame_end)
		else $error("error result carries payload data");

	a_count_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> pay_cnt_q < frame_len_q && frame_len_q <= max_frame
		|| $past(max_frame) != max_frame || pay_cnt_q < frame_len_q)
		else $error("payload count reached frame length inside payload phase");

	a_err_once: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.vld && res.err |-> phase_nxt == PH_ERROR)
		else $error("error result without entering error phase");

endmodule
